FILE: hw/rtl/bsc_pkg.sv
// Shared types, constants and register indexes for the barometric compensation block.
`timescale 1ns / 1ps

package bsc_pkg;

	localparam int RAW_WIDTH_DEF = 20;
	localparam int RAW_BITS      = 20;
	localparam int PRESS_BITS    = 25;

	localparam logic [1:0] CFG_TEMP       = 2'd0;
	localparam logic [1:0] CFG_PRESS_LOW  = 2'd1;
	localparam logic [1:0] CFG_PRESS_HIGH = 2'd2;
	localparam logic [1:0] CFG_PRESS_NINE = 2'd3;

	typedef struct packed {
		logic [RAW_BITS-1:0] raw_pressure;
		logic [RAW_BITS-1:0] raw_temperature;
	} bsc_in_t;

	typedef struct packed {
		logic signed [15:0]      temperature_tenths;
		logic [PRESS_BITS-1:0]   pressure_now;
		logic [PRESS_BITS-1:0]   pressure_smoothed;
		logic                    divide_fault;
	} bsc_out_t;

	// status of a multi-cycle arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

FILE: hw/rtl/bsc_mul.sv
// Low 64 bits of a 64x64 product from one shared 32x32 multiplier.
`timescale 1ns / 1ps

module bsc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         a,
	input  logic [63:0]         b,
	output logic [63:0]         p,
	output bsc_pkg::unit_stat_t stat
);
	import bsc_pkg::*;

	logic [63:0] a_q, b_q, acc_q, prod_q;
	logic [1:0]  cnt_q;
	logic        busy_q, done_q;
	logic [31:0] op_a, op_b;

	// lo*lo, lo*hi, hi*lo; hi*hi falls off the top
	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = a_q[31:0];
				op_b = b_q[31:0];
			end
			2'd1: begin
				op_a = a_q[31:0];
				op_b = b_q[63:32];
			end
			default: begin
				op_a = a_q[63:32];
				op_b = b_q[31:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= busy_q && (cnt_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 2'd3)
				prod_q <= {32'd0, op_a} * {32'd0, op_b};
			if (cnt_q == 2'd1)
				acc_q <= acc_q + prod_q;
			else if (cnt_q != 2'd0)
				acc_q <= acc_q + {prod_q[31:0], 32'd0};
		end
	end

	assign p         = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("mul did not go busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("mul done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("mul restarted while busy");

endmodule

FILE: hw/rtl/bsc_div.sv
// Signed 64-bit divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps

module bsc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         num,
	input  logic [63:0]         den,
	output logic [63:0]         quo,
	output bsc_pkg::unit_stat_t stat
);
	import bsc_pkg::*;

	logic [63:0] quo_q, rem_q, den_q;
	logic [6:0]  cnt_q;
	logic        neg_q, busy_q, done_q;
	logic [64:0] sh, diff;

	assign sh   = {rem_q, quo_q[63]};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 7'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num[63] ? (64'd0 - num) : num;
			den_q <= den[63] ? (64'd0 - den) : den;
			rem_q <= '0;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q) begin
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= sh[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quo       = neg_q ? (64'd0 - quo_q) : quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("div did not go busy");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q != 7'd0)
		else $error("div count ran out while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("div restarted while busy");

endmodule

FILE: hw/rtl/baro_sensor_compensation.sv
// Top level: barometric temperature and pressure compensation with smoothing filter.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------------
//   in      | in  | in_valid / in_ready  | in_data: raw_pressure, raw_temperature
//   out     | out | out_valid/out_ready  | out_data: temp, pressure, smoothed, fault
//   cfg     | in  | cfg_valid/cfg_ready  | cfg_index (2b), cfg_data (64b)
//
// Each word runs 14 products on the shared 32x32 multiplier (each issued,
// worked in four partial steps, and captured) plus one signed divide for the
// pressure quotient before the next word is accepted. The filter's divide by 5
// is a reciprocal product. A zero divisor skips the pressure path.
// in_ready is high only in idle; a result waits in the output register
// while the next word is already being worked on, and the output step
// stalls only while the previous word is still unaccepted.
// Reset clears control, coefficients and the filter state.
`timescale 1ns / 1ps

module baro_sensor_compensation #(
	parameter int RAW_WIDTH = bsc_pkg::RAW_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bsc_pkg::bsc_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bsc_pkg::bsc_out_t out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [63:0]      cfg_data
);
	import bsc_pkg::*;

	// only the top RAW_WIDTH bits of each raw field are used
	localparam logic [RAW_BITS-1:0] RAW_MASK =
		~((RAW_BITS'(1) << (RAW_BITS - RAW_WIDTH)) - RAW_BITS'(1));

	// x / 5 == (x * ceil(2^34 / 5)) >> 34, exact for x below 2^34
	localparam logic [63:0] DIV5_RECIP = 64'd3435973837;
	localparam int          DIV5_SHIFT = 34;

	typedef enum logic [4:0] {
		S_IDLE, S_T1, S_T2, S_T3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
		S_NUM, S_DIV, S_Q1, S_Q2, S_Q3, S_FILT, S_OUT
	} state_t;

	state_t state_q;
	logic   phase_q;

	// calibration registers
	logic [47:0] tc_q;
	logic [63:0] pcl_q, pch_q;
	logic [15:0] p9_q;

	logic [RAW_BITS-1:0]   up_q, ut_q;
	logic [63:0]           v1_q, x_q, acc_q, sq_q, tfine_q, p_q;
	logic [PRESS_BITS-1:0] pnow_q, sm_q;
	logic                  fault_q;
	bsc_out_t              out_q;
	logic                  out_valid_q;
	logic                  out_load;

	// output register takes a new word when empty or being drained
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// coefficients extended to 64 bits: t1 and p1 zero-extended, the rest sign-extended
	logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {48'd0, tc_q[15:0]};
	assign t2 = {{48{tc_q[31]}}, tc_q[31:16]};
	assign t3 = {{48{tc_q[47]}}, tc_q[47:32]};
	assign p1 = {48'd0, pcl_q[15:0]};
	assign p2 = {{48{pcl_q[31]}}, pcl_q[31:16]};
	assign p3 = {{48{pcl_q[47]}}, pcl_q[47:32]};
	assign p4 = {{48{pcl_q[63]}}, pcl_q[63:48]};
	assign p5 = {{48{pch_q[15]}}, pch_q[15:0]};
	assign p6 = {{48{pch_q[31]}}, pch_q[31:16]};
	assign p7 = {{48{pch_q[47]}}, pch_q[47:32]};
	assign p8 = {{48{pch_q[63]}}, pch_q[63:48]};
	assign p9 = {{48{p9_q[15]}}, p9_q};

	logic [63:0] ut64, up64, ta, tb, dt, qq, num0, filt_num;
	assign ut64     = {44'd0, ut_q};
	assign up64     = {44'd0, up_q};
	assign ta       = (ut64 >> 3) - (t1 << 1);
	assign tb       = (ut64 >> 4) - t1;
	assign dt       = tfine_q - 64'd128000;
	assign qq       = $signed(p_q) >>> 13;
	assign num0     = ((64'd1048576 - up64) << 31) - acc_q;
	assign filt_num = {39'd0, pnow_q} + {37'd0, sm_q, 2'b00};

	// shared units
	logic        mul_start, div_start;
	logic [63:0] mul_a, mul_b, mul_p, div_n, div_d, div_q;
	unit_stat_t  mul_stat, div_stat;
	logic        is_div;

	assign is_div = (state_q == S_DIV);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_n = x_q;
		div_d = v1_q;
		case (state_q)
			S_T1: begin mul_a = ta;               mul_b = t2; end
			S_T2: begin mul_a = tb;               mul_b = tb; end
			S_T3: begin mul_a = x_q;              mul_b = t3; end
			S_P4: begin mul_a = dt;               mul_b = dt; end
			S_P5: begin mul_a = sq_q;             mul_b = p6; end
			S_P6: begin mul_a = dt;               mul_b = p5; end
			S_P7: begin mul_a = sq_q;             mul_b = p3; end
			S_P8: begin mul_a = dt;               mul_b = p2; end
			S_P9: begin mul_a = 64'h0000_8000_0000_0000 + x_q; mul_b = p1; end
			S_NUM: begin mul_a = num0;            mul_b = 64'd3125; end
			S_Q1: begin mul_a = p9;               mul_b = qq; end
			S_Q2: begin mul_a = x_q;              mul_b = qq; end
			S_Q3: begin mul_a = p8;               mul_b = p_q; end
			S_FILT: begin mul_a = filt_num;       mul_b = DIV5_RECIP; end
			default: ;
		endcase
	end

	assign mul_start = !phase_q && !is_div && (state_q != S_IDLE) && (state_q != S_OUT);
	assign div_start = !phase_q && is_div;

	bsc_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .p(mul_p), .stat(mul_stat)
	);

	bsc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_n), .den(div_d), .quo(div_q), .stat(div_stat)
	);

	logic unit_done;
	assign unit_done = phase_q && (is_div ? div_stat.done : mul_stat.done);

	// final pressure assembly and clamp
	logic [63:0] pfin, pin;
	assign pin  = p_q + v1_q + 64'($signed(mul_p) >>> 19);
	assign pfin = 64'($signed(pin) >>> 8) + (p7 << 4);

	logic [PRESS_BITS-1:0] pclamp;
	always_comb begin
		if (pfin[63])
			pclamp = '0;
		else if (pfin[62:PRESS_BITS] != '0)
			pclamp = '1;
		else
			pclamp = pfin[PRESS_BITS-1:0];
	end

	// temperature in tenths, clamped to 16 bits
	logic [63:0]        tsh;
	logic signed [15:0] tsat;
	assign tsh = $signed(tfine_q) >>> 9;
	always_comb begin
		if (tsh[63] && (tsh[62:15] != '1))
			tsat = 16'sh8000;
		else if (!tsh[63] && (tsh[62:15] != '0))
			tsat = 16'sh7fff;
		else
			tsat = tsh[15:0];
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			sm_q        <= '0;
			tc_q        <= '0;
			pcl_q       <= '0;
			pch_q       <= '0;
			p9_q        <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TEMP:       tc_q  <= cfg_data[47:0];
					CFG_PRESS_LOW:  pcl_q <= cfg_data;
					CFG_PRESS_HIGH: pch_q <= cfg_data;
					CFG_PRESS_NINE: p9_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (state_q == S_IDLE) begin
				if (in_valid) begin
					up_q    <= in_data.raw_pressure & RAW_MASK;
					ut_q    <= in_data.raw_temperature & RAW_MASK;
					fault_q <= 1'b0;
					state_q <= S_T1;
					phase_q <= 1'b0;
				end
			end else if (state_q == S_OUT) begin
				if (out_load) begin
					out_q.temperature_tenths <= tsat;
					out_q.pressure_now       <= fault_q ? '0 : pnow_q;
					out_q.pressure_smoothed  <= sm_q;
					out_q.divide_fault       <= fault_q;
					state_q                  <= S_IDLE;
				end
			end else if (!phase_q) begin
				phase_q <= 1'b1;
			end else if (unit_done) begin
				phase_q <= 1'b0;
				case (state_q)
					S_T1: begin
						v1_q    <= $signed(mul_p) >>> 11;
						state_q <= S_T2;
					end
					S_T2: begin
						x_q     <= $signed(mul_p) >>> 12;
						state_q <= S_T3;
					end
					S_T3: begin
						tfine_q <= v1_q + 64'($signed(mul_p) >>> 14);
						state_q <= S_P4;
					end
					S_P4: begin
						sq_q    <= mul_p;
						state_q <= S_P5;
					end
					S_P5: begin
						acc_q   <= mul_p;
						state_q <= S_P6;
					end
					S_P6: begin
						acc_q   <= acc_q + (mul_p << 17) + (p4 << 35);
						state_q <= S_P7;
					end
					S_P7: begin
						x_q     <= $signed(mul_p) >>> 8;
						state_q <= S_P8;
					end
					S_P8: begin
						x_q     <= x_q + (mul_p << 12);
						state_q <= S_P9;
					end
					S_P9: begin
						v1_q <= $signed(mul_p) >>> 33;
						// zero divisor: flag, hold filter, skip pressure
						if (64'($signed(mul_p) >>> 33) == 64'd0) begin
							fault_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							state_q <= S_NUM;
						end
					end
					S_NUM: begin
						x_q     <= mul_p;
						state_q <= S_DIV;
					end
					S_DIV: begin
						p_q     <= div_q;
						state_q <= S_Q1;
					end
					S_Q1: begin
						x_q     <= mul_p;
						state_q <= S_Q2;
					end
					S_Q2: begin
						v1_q    <= $signed(mul_p) >>> 25;
						state_q <= S_Q3;
					end
					S_Q3: begin
						pnow_q  <= pclamp;
						state_q <= S_FILT;
					end
					S_FILT: begin
						sm_q    <= mul_p[DIV5_SHIFT +: PRESS_BITS];
						state_q <= S_OUT;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_fault |-> out_data.pressure_now == '0)
		else $error("fault word carries nonzero pressure");
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sm_q) |-> $past(state_q == S_FILT))
		else $error("filter state changed outside filter step");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mul_stat.busy && !div_stat.busy)
		else $error("arith unit busy while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && div_stat.busy))
		else $error("both arith units busy");

endmodule
